// ===== design/tts_pkg.sv =====
// ----------------------------------------------------------------------------
// Touch-to-screen stabilizer package
// Shared types, register indexes and reset values.
// ----------------------------------------------------------------------------
package tts_pkg;

    localparam int CfgIdxW = 3;
    localparam int CfgDataW = 64;

    localparam logic [CfgIdxW-1:0] REG_ACTIVE_RECT   = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_MAP_RECT      = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_SCREEN_SIZE   = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_SCREEN_ORIGIN = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_JITTER_LIMIT  = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_SMOOTH_GAIN   = 3'd5;

    localparam logic [63:0] ACTIVE_RECT_RST   = 64'd2147516416;
    localparam logic [63:0] MAP_RECT_RST      = 64'd2147516416;
    localparam logic [31:0] SCREEN_SIZE_RST   = 32'd125830200;
    localparam logic [31:0] SCREEN_ORIGIN_RST = 32'd0;
    localparam logic [15:0] JITTER_LIMIT_RST  = 16'd256;
    localparam logic [15:0] SMOOTH_GAIN_RST   = 16'd29491;

    localparam logic [15:0] ONE_Q15 = 16'h8000;
    localparam logic [23:0] PIX_MAX = 24'hFFFFFF;

    localparam int QueueDepth = 2;

    // Mapped pixel pair handed from the front to the back part.
    typedef struct packed {
        logic [23:0] pix_x;
        logic [23:0] pix_y;
    } tts_pix_t;

    // Queue status seen by the front part.
    typedef struct packed {
        logic full;
        logic empty;
    } tts_q_stat_t;

endpackage

// ===== design/tts_front.sv =====
// ----------------------------------------------------------------------------
// Front part: clamp, divide and map one touch position to Q16.8 pixels
// One shared restoring divider runs both axes, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module tts_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic signed [16:0]    s_touch_x,
    input  logic signed [16:0]    s_touch_y,
    input  logic [63:0]           active_rect,
    input  logic [63:0]           map_rect,
    input  logic [31:0]           screen_size,
    input  tts_pkg::tts_q_stat_t  q_stat,
    output logic                  q_push,
    output tts_pkg::tts_pix_t     q_data
);
    import tts_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CLASS = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_MUL1  = 3'd3;
    localparam logic [2:0] ST_MUL2  = 3'd4;
    localparam logic [2:0] ST_PUSH  = 3'd5;

    logic [2:0]         state_reg, state_next;
    logic               axis_reg;          // 0: x, 1: y
    logic signed [16:0] tx_reg, ty_reg;
    logic [4:0]         cnt_reg;
    logic [31:0]        rem_reg;
    logic [15:0]        quo_reg;
    logic [16:0]        ratio_reg;
    logic [47:0]        m_reg;
    logic [23:0]        px_reg, py_reg;

    logic signed [16:0] n;
    logic [15:0]        ao, aw, mo, mw, sz;
    logic signed [18:0] diff;
    logic signed [18:0] hi_edge;
    logic [31:0]        rem_sh;
    logic [16:0]        rem_hi;
    logic               sub_ok;
    logic [47:0]        p_full;
    logic [23:0]        p_sat;

    assign n  = axis_reg ? ty_reg : tx_reg;
    assign ao = axis_reg ? active_rect[47:32] : active_rect[63:48];
    assign aw = axis_reg ? active_rect[15:0]  : active_rect[31:16];
    assign mo = axis_reg ? map_rect[47:32]    : map_rect[63:48];
    assign mw = axis_reg ? map_rect[15:0]     : map_rect[31:16];
    assign sz = axis_reg ? screen_size[15:0]  : screen_size[31:16];

    assign diff    = 19'(n) - $signed({3'b000, ao});
    assign hi_edge = $signed({3'b000, ao}) + $signed({3'b000, aw});
    assign rem_sh  = {rem_reg[30:0], 1'b0};
    // The shifted partial remainder needs 17 bits when the divisor uses all 16.
    assign rem_hi  = rem_reg[31:15];
    assign sub_ok  = (rem_hi >= {1'b0, aw});
    // Product fits 48 bits: m below 2^32 times a 16-bit size.
    assign p_full  = (m_reg * {32'd0, sz}) >> 22;
    assign p_sat   = (|p_full[47:24]) ? PIX_MAX : p_full[23:0];

    assign s_ready = (state_reg == ST_IDLE);
    assign q_push  = (state_reg == ST_PUSH) && !q_stat.full;
    assign q_data  = '{pix_x: px_reg, pix_y: py_reg};

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_valid) state_next = ST_CLASS;
            ST_CLASS: begin
                if (diff < 0 || 19'(n) > hi_edge || aw == 16'd0) state_next = ST_MUL1;
                else state_next = ST_DIV;
            end
            ST_DIV:   if (cnt_reg == 5'd0) state_next = ST_MUL1;
            ST_MUL1:  state_next = ST_MUL2;
            ST_MUL2:  state_next = axis_reg ? ST_PUSH : ST_CLASS;
            ST_PUSH:  if (!q_stat.full) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            axis_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_IDLE) axis_reg <= 1'b0;
            else if (state_reg == ST_MUL2) axis_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                tx_reg <= s_touch_x;
                ty_reg <= s_touch_y;
            end
            ST_CLASS: begin
                if (diff < 0 || aw == 16'd0) begin
                    ratio_reg <= (19'(n) > hi_edge) ? {1'b0, ONE_Q15} : 17'd0;
                end else if (19'(n) > hi_edge) begin
                    ratio_reg <= {1'b0, ONE_Q15};
                end
                // Dividend (n - ao) << 15 is at most 17 + 15 bits.
                rem_reg <= {15'd0, diff[16:0]};
                quo_reg <= 16'd0;
                cnt_reg <= 5'd30;
            end
            ST_DIV: begin
                // Restoring division of diff<<15 by aw: feed the 15 zero bits last.
                if (sub_ok) begin
                    rem_reg <= {16'(rem_hi - {1'b0, aw}), rem_sh[15:0]};
                    quo_reg <= {quo_reg[14:0], 1'b1};
                end else begin
                    rem_reg <= rem_sh;
                    quo_reg <= {quo_reg[14:0], 1'b0};
                end
                if (cnt_reg == 5'd0) ratio_reg <= {1'b0, quo_reg[14:0], sub_ok};
                cnt_reg <= cnt_reg - 5'd1;
            end
            ST_MUL1: m_reg <= 48'(ratio_reg * mw) + {17'd0, mo, 15'd0};
            ST_MUL2: begin
                if (axis_reg) py_reg <= p_sat;
                else px_reg <= p_sat;
            end
            default: ;
        endcase
    end
endmodule

// ===== design/tts_queue.sv =====
// ----------------------------------------------------------------------------
// Pixel queue
// Short FIFO of mapped positions between the front and back parts.
// ----------------------------------------------------------------------------
module tts_queue #(
    parameter int Depth = tts_pkg::QueueDepth
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  tts_pkg::tts_pix_t     push_data,
    input  logic                  pop,
    output tts_pkg::tts_pix_t     pop_data,
    output tts_pkg::tts_q_stat_t  stat
);
    import tts_pkg::*;

    localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

    tts_pix_t       mem_reg [Depth];
    logic [AW-1:0]  wr_reg, rd_reg;
    logic [AW:0]    cnt_reg;

    assign stat.full  = (cnt_reg == (AW+1)'(Depth));
    assign stat.empty = (cnt_reg == '0);
    assign pop_data   = mem_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wr_reg <= (wr_reg == AW'(Depth-1)) ? '0 : wr_reg + 1'b1;
            if (pop)  rd_reg <= (rd_reg == AW'(Depth-1)) ? '0 : rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_reg] <= push_data;
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.full |-> !push || pop) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.empty |-> !pop) else $error("queue underflow");
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> cnt_reg == $past(cnt_reg) + 1'b1) else $error("count");
`endif
endmodule

// ===== design/tts_back.sv =====
// ----------------------------------------------------------------------------
// Back part: jitter test, smoothing and screen clamp
// Holds the previous position and drives the result register.
// ----------------------------------------------------------------------------
module tts_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_empty,
    input  tts_pkg::tts_pix_t  q_data,
    output logic               q_pop,
    input  logic [31:0]        screen_size,
    input  logic [31:0]        screen_origin,
    input  logic [15:0]        jitter_limit,
    input  logic [15:0]        smooth_gain,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_cursor_x,
    output logic signed [15:0] m_cursor_y,
    output logic               m_held
);
    import tts_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SQ   = 2'd1;
    localparam logic [1:0] ST_STEP = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]         state_reg;
    logic               have_prev_reg;
    logic [23:0]        prev_x_reg, prev_y_reg;
    logic [23:0]        nx_reg, ny_reg;
    logic signed [24:0] dx_reg, dy_reg;
    logic [49:0]        dist2_reg;
    logic [23:0]        pos_x_reg, pos_y_reg;
    logic               held_reg;

    logic [15:0]        gain;
    logic signed [24:0] dx, dy;
    logic signed [41:0] prod_x, prod_y;
    logic [31:0]        lim2;
    logic signed [24:0] new_x, new_y;

    assign gain = (smooth_gain > ONE_Q15) ? ONE_Q15 : smooth_gain;
    assign dx   = $signed({1'b0, q_data.pix_x}) - $signed({1'b0, prev_x_reg});
    assign dy   = $signed({1'b0, q_data.pix_y}) - $signed({1'b0, prev_y_reg});
    assign lim2 = jitter_limit * jitter_limit;
    assign prod_x = dx_reg * $signed({1'b0, gain});
    assign prod_y = dy_reg * $signed({1'b0, gain});
    // Arithmetic shift floors toward minus infinity.
    assign new_x  = $signed({1'b0, prev_x_reg}) + 25'(prod_x >>> 15);
    assign new_y  = $signed({1'b0, prev_y_reg}) + 25'(prod_y >>> 15);

    function automatic logic [15:0] to_screen(input logic [23:0] pos, input logic [15:0] sz,
                                              input logic [15:0] org);
        logic signed [17:0] px;
        logic signed [17:0] v;
        if (sz == 16'd0) px = '0;
        else if (pos >= {sz, 8'd0}) px = $signed({2'b00, sz}) - 18'sd1;
        else px = $signed({2'b00, pos[23:8]});
        v = px + 18'(signed'(org));
        if (v > 18'sd32767) v = 18'sd32767;
        if (v < -18'sd32768) v = -18'sd32768;
        return v[15:0];
    endfunction

    assign q_pop = (state_reg == ST_IDLE) && !q_empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            have_prev_reg <= 1'b0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            m_valid       <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: if (!q_empty) state_reg <= ST_SQ;
                ST_SQ: state_reg <= ST_STEP;
                ST_STEP: begin
                    state_reg <= ST_OUT;
                    if (!have_prev_reg) begin
                        pos_x_reg <= nx_reg; pos_y_reg <= ny_reg; held_reg <= 1'b0;
                    end else if (dist2_reg < {18'd0, lim2}) begin
                        pos_x_reg <= prev_x_reg; pos_y_reg <= prev_y_reg; held_reg <= 1'b1;
                    end else begin
                        pos_x_reg <= new_x[23:0]; pos_y_reg <= new_y[23:0]; held_reg <= 1'b0;
                    end
                end
                ST_OUT: if (!m_valid || m_ready) begin
                    state_reg     <= ST_IDLE;
                    have_prev_reg <= 1'b1;
                    prev_x_reg    <= pos_x_reg;
                    prev_y_reg    <= pos_y_reg;
                    m_valid       <= 1'b1;
                end
                default: state_reg <= ST_IDLE;
            endcase
            if (m_valid && m_ready && !(state_reg == ST_OUT)) m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            nx_reg <= q_data.pix_x;
            ny_reg <= q_data.pix_y;
            dx_reg <= dx;
            dy_reg <= dy;
        end
        if (state_reg == ST_SQ)
            dist2_reg <= 50'(dx_reg * dx_reg) + 50'(dy_reg * dy_reg);
        if (state_reg == ST_OUT && (!m_valid || m_ready)) begin
            m_cursor_x <= to_screen(pos_x_reg, screen_size[31:16], screen_origin[31:16]);
            m_cursor_y <= to_screen(pos_y_reg, screen_size[15:0], screen_origin[15:0]);
            m_held     <= held_reg;
        end
    end

`ifndef SYNTHESIS
    a_hold_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid && $stable(m_cursor_x) && $stable(m_held))
        else $error("result changed under stall");
    a_prev_after_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && (!m_valid || m_ready)) |=> have_prev_reg)
        else $error("previous position not recorded");
    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> state_reg == ST_SQ) else $error("pop outside idle");
`endif
endmodule

// ===== design/touch_to_screen_stabilizer.sv =====
// ----------------------------------------------------------------------------
// Touch-to-screen stabilizer
// Maps a normalized touch to screen pixels with deadband and smoothing.
// ----------------------------------------------------------------------------
//  channel  | handshake         | payload
//  s_       | s_valid/s_ready   | s_touch_x, s_touch_y
//  m_       | m_valid/m_ready   | m_cursor_x, m_cursor_y, m_held
//  cfg      | cfg_we            | cfg_index, cfg_wdata
//
// The front part sends each axis whose touch lies inside the active range
// through the shared one-bit-a-cycle divider, and waits in its push state
// while the queue is full. The back part waits on m_ready to hand out a result.
// Reset is synchronous and active low and clears the previous position.
// A two-entry queue lets the front part take a new item while results stall.
// ----------------------------------------------------------------------------
module touch_to_screen_stabilizer #(
    parameter int QDepth = tts_pkg::QueueDepth
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [tts_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [tts_pkg::CfgDataW-1:0]  cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [16:0]            s_touch_x,
    input  logic signed [16:0]            s_touch_y,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [15:0]            m_cursor_x,
    output logic signed [15:0]            m_cursor_y,
    output logic                          m_held
);
    import tts_pkg::*;

    logic [63:0] active_rect_reg, map_rect_reg;
    logic [31:0] screen_size_reg, screen_origin_reg;
    logic [15:0] jitter_limit_reg, smooth_gain_reg;

    tts_q_stat_t q_stat;
    tts_pix_t    push_data, pop_data;
    logic        q_push, q_pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_rect_reg   <= ACTIVE_RECT_RST;
            map_rect_reg      <= MAP_RECT_RST;
            screen_size_reg   <= SCREEN_SIZE_RST;
            screen_origin_reg <= SCREEN_ORIGIN_RST;
            jitter_limit_reg  <= JITTER_LIMIT_RST;
            smooth_gain_reg   <= SMOOTH_GAIN_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_ACTIVE_RECT:   active_rect_reg   <= cfg_wdata;
                REG_MAP_RECT:      map_rect_reg      <= cfg_wdata;
                REG_SCREEN_SIZE:   screen_size_reg   <= cfg_wdata[31:0];
                REG_SCREEN_ORIGIN: screen_origin_reg <= cfg_wdata[31:0];
                REG_JITTER_LIMIT:  jitter_limit_reg  <= cfg_wdata[15:0];
                REG_SMOOTH_GAIN:   smooth_gain_reg   <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    tts_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_touch_x(s_touch_x), .s_touch_y(s_touch_y),
        .active_rect(active_rect_reg), .map_rect(map_rect_reg),
        .screen_size(screen_size_reg),
        .q_stat(q_stat), .q_push(q_push), .q_data(push_data)
    );

    tts_queue #(.Depth(QDepth)) u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .push(q_push), .push_data(push_data),
        .pop(q_pop), .pop_data(pop_data), .stat(q_stat)
    );

    tts_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_empty(q_stat.empty), .q_data(pop_data), .q_pop(q_pop),
        .screen_size(screen_size_reg), .screen_origin(screen_origin_reg),
        .jitter_limit(jitter_limit_reg), .smooth_gain(smooth_gain_reg),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_cursor_x(m_cursor_x), .m_cursor_y(m_cursor_y), .m_held(m_held)
    );
endmodule
